>>> rtl/oqd_pkg.sv
// Shared types and constants for the ordered queue with delete by value.
package oqd_pkg;

    // Command codes carried in the low bits of the input tdata.
    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_CLEAR   = 2'd3
    } oqd_cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } oqd_status_t;

    // Width of the fixed input word fields and of the reported count.
    localparam int FIELD_W     = 32;
    localparam int COUNT_OUT_W = 7;

    // Input tdata layout.
    localparam int CMD_LSB       = 0;
    localparam int VALUE_LSB     = 2;
    localparam int NEW_VALUE_LSB = VALUE_LSB + FIELD_W;
    localparam int IN_TDATA_W    = 72;

    // Output tdata layout.
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - COUNT_OUT_W;

    // Depth of the command queue between the front and back parts.
    localparam int FIFO_DEPTH = 2;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        oqd_cmd_t kind;
        logic     search;
    } oqd_op_t;

    // One result item.
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] entry_count;
        oqd_status_t            status;
    } oqd_result_t;

endpackage

>>> rtl/oqd_front.sv
// Front part: accepts input transfers, decodes and classifies each command.
module oqd_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields from bit 0: cmd[1:0], value[33:2], new_value[65:34], zero pad
    input  logic [oqd_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                          op_valid,
    input  logic                          op_ready,
    output oqd_pkg::oqd_op_t              op,
    output logic [DATA_WIDTH-1:0]         key,
    output logic [DATA_WIDTH-1:0]         repl
);
    import oqd_pkg::*;

    logic                  valid_reg;
    oqd_op_t               op_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] repl_reg;

    oqd_op_t               op_dec;
    logic [DATA_WIDTH-1:0] key_dec;
    logic [DATA_WIDTH-1:0] repl_dec;
    logic                  take;

    // The holding register frees up when its command moves into the queue.
    assign s_tready = !valid_reg || op_ready;
    assign take     = s_tvalid && s_tready;

    // Decode the command and mark the ones that must search the store.
    always_comb
    begin
        op_dec.kind = oqd_cmd_t'(s_tdata[CMD_LSB +: 2]);
        unique case (op_dec.kind) inside
            CMD_REMOVE, CMD_REPLACE: op_dec.search = 1'b1;
            default:                 op_dec.search = 1'b0;
        endcase
        // Words are stored at the block's data width, sign-extended if wider.
        key_dec  = DATA_WIDTH'($signed(s_tdata[VALUE_LSB +: FIELD_W]));
        repl_dec = DATA_WIDTH'($signed(s_tdata[NEW_VALUE_LSB +: FIELD_W]));
    end

    // Valid flag of the holding register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload of the holding register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg   <= op_dec;
            key_reg  <= key_dec;
            repl_reg <= repl_dec;
        end
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;
    assign key      = key_reg;
    assign repl     = repl_reg;

endmodule

>>> rtl/oqd_fifo.sv
// Short command queue that decouples the front part from the back part.
module oqd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import oqd_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0]  slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push;
    logic              pop;

    assign in_ready  = fill_reg != FILL_W'(FIFO_DEPTH);
    assign out_valid = fill_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> rtl/oqd_back.sv
// Back part: holds the entry memory, scans and shifts it, and registers results.
module oqd_back #(
    parameter int QUEUE_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  oqd_pkg::oqd_op_t      op,
    input  logic [DATA_WIDTH-1:0] key,
    input  logic [DATA_WIDTH-1:0] repl,
    output logic                  res_valid,
    input  logic                  res_ready,
    output oqd_pkg::oqd_result_t  res
);
    import oqd_pkg::*;

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W  = CNT_W + COUNT_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SHIFT
    } state_t;

    // Entry memory with a registered read port.
    logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;

    state_t                state_reg,     state_next;
    logic [ADDR_W-1:0]     idx_reg,       idx_next;
    logic [CNT_W-1:0]      count_reg,     count_next;
    oqd_cmd_t              kind_reg,      kind_next;
    logic [DATA_WIDTH-1:0] key_reg,       key_next;
    logic [DATA_WIDTH-1:0] repl_reg,      repl_next;
    logic                  out_valid_reg, out_valid_next;
    oqd_result_t           out_res_reg,   out_res_next;

    logic              slot_free;
    logic              full;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  idx_p2;
    logic              finish;
    oqd_status_t       status_v;
    logic [EXT_W-1:0]  cnt_wide;

    // A new command starts only when its result will have a free slot.
    assign slot_free = !out_valid_reg || res_ready;
    assign op_ready  = (state_reg == S_IDLE) && slot_free;
    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign idx_p1    = CNT_W'(idx_reg) + 1'b1;
    assign idx_p2    = CNT_W'(idx_reg) + 2'd2;

    // Sequencer: search one entry a cycle, then for a remove shift one entry a cycle.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        repl_next      = repl_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_res_next   = out_res_reg;
        finish         = 1'b0;
        status_v       = ST_DONE;
        we             = 1'b0;
        waddr          = idx_reg;
        wdata          = repl_reg;
        raddr          = idx_p1[ADDR_W-1:0];
        cnt_wide       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                raddr = '0;
                if (op_valid && slot_free)
                begin
                    kind_next = op.kind;
                    key_next  = key;
                    repl_next = repl;
                    if (op.search)
                    begin
                        // Nothing can match in an empty queue.
                        if (count_reg == '0)
                        begin
                            finish   = 1'b1;
                            status_v = ST_NOT_FOUND;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_CMP;
                        end
                    end
                    else if (op.kind == CMD_CLEAR)
                    begin
                        count_next = '0;
                        finish     = 1'b1;
                    end
                    else if (full)
                    begin
                        finish   = 1'b1;
                        status_v = ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[ADDR_W-1:0];
                        wdata      = key;
                        count_next = count_reg + 1'b1;
                        finish     = 1'b1;
                    end
                end
            end
            S_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    if (kind_reg == CMD_REPLACE)
                    begin
                        we     = 1'b1;
                        finish = 1'b1;
                    end
                    else if (idx_p1 == count_reg)
                    begin
                        // The match is the tail entry: nothing to close up.
                        count_next = count_reg - 1'b1;
                        finish     = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_p1 == count_reg)
                begin
                    finish   = 1'b1;
                    status_v = ST_NOT_FOUND;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                // Move the entry read last cycle one place toward the head.
                raddr = idx_p2[ADDR_W-1:0];
                we    = 1'b1;
                wdata = rd_data_reg;
                if (idx_p2 == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    finish     = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the result register when a command completes.
        if (finish)
        begin
            cnt_wide                 = EXT_W'(count_next);
            state_next               = S_IDLE;
            out_valid_next           = 1'b1;
            out_res_next.status      = status_v;
            out_res_next.entry_count = cnt_wide[COUNT_OUT_W-1:0];
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            kind_reg      <= CMD_APPEND;
            key_reg       <= '0;
            repl_reg      <= '0;
            out_res_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            kind_reg      <= kind_next;
            key_reg       <= key_next;
            repl_reg      <= repl_next;
            out_res_reg   <= out_res_next;
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

endmodule

>>> rtl/ordered_queue_delete_by_value.sv
// Top level of the ordered queue with search, delete and replace by value.
//
//  Channel | Direction | tdata fields from bit 0                          | Width
//  s_*     | in        | cmd[1:0], value[33:2], new_value[65:34], pad     | 72
//  m_*     | out       | status[1:0], entry_count[8:2], pad               | 16
//
// Append and clear finish in the back part's idle state; so do remove and
// replace on an empty queue. Otherwise remove and replace scan the entry
// memory one entry a cycle, from the head up to the first match or the tail.
// A remove then closes the gap one entry a cycle, moving each later entry
// one place toward the head. Front register and command queue keep taking
// commands while the back part works. Reset empties the queue at once; a
// stalled result holds in the output register and pauses the back part.
module ordered_queue_delete_by_value #(
    parameter int QUEUE_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0: cmd[1:0], value[33:2], new_value[65:34], zero pad
    input  logic [oqd_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0: status[1:0], entry_count[8:2], zero pad
    output logic [oqd_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import oqd_pkg::*;

    localparam int Q_W = $bits(oqd_op_t) + 2 * DATA_WIDTH;

    logic                  f_valid;
    logic                  f_ready;
    oqd_op_t               f_op;
    logic [DATA_WIDTH-1:0] f_key;
    logic [DATA_WIDTH-1:0] f_repl;

    logic                  b_valid;
    logic                  b_ready;
    logic [Q_W-1:0]        b_data;
    oqd_op_t               b_op;
    logic [DATA_WIDTH-1:0] b_key;
    logic [DATA_WIDTH-1:0] b_repl;

    oqd_result_t           res;

    // Front part: accept and classify.
    oqd_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .op_valid (f_valid),
        .op_ready (f_ready),
        .op       (f_op),
        .key      (f_key),
        .repl     (f_repl)
    );

    // Command queue between the two parts.
    oqd_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_op, f_key, f_repl}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    assign {b_op, b_key, b_repl} = b_data;

    // Back part: memory scan, shift and result register.
    oqd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (b_valid),
        .op_ready  (b_ready),
        .op        (b_op),
        .key       (b_key),
        .repl      (b_repl),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, res.entry_count, res.status};

endmodule

>>> rtl/oqd_checker.sv
// Port-level checker for the ordered queue, bound to the top level.
module oqd_checker #(
    parameter int QUEUE_DEPTH = 64
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [oqd_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import oqd_pkg::*;

    localparam logic [COUNT_OUT_W-1:0] DEPTH_OUT = COUNT_OUT_W'(QUEUE_DEPTH);

    logic [STATUS_W-1:0]    status_f;
    logic [COUNT_OUT_W-1:0] count_f;

    assign status_f = m_tdata[STATUS_W-1:0];
    assign count_f  = m_tdata[STATUS_W +: COUNT_OUT_W];

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only defined status codes appear.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status_f == ST_DONE || status_f == ST_NOT_FOUND ||
                      status_f == ST_FULL))
        else $error("undefined status code");

    // The reported count never exceeds the queue depth.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (QUEUE_DEPTH > 127 || count_f <= DEPTH_OUT))
        else $error("entry count above depth");

    // A full report always comes with a full queue.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status_f == ST_FULL |-> count_f == DEPTH_OUT)
        else $error("full status without a full queue");

endmodule

bind ordered_queue_delete_by_value oqd_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_oqd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/ordered_queue_delete_by_value_tb.sv
// Self-checking testbench for the ordered queue with search, delete and replace by value.
`timescale 1ns / 100ps

module ordered_queue_delete_by_value_tb;

    import oqd_pkg::*;

    localparam int QUEUE_DEPTH    = 64;
    localparam int DATA_WIDTH     = 32;
    localparam int TOTAL_ITEMS    = 1550;
    localparam int CALM_ITEMS     = 150;
    localparam int PAUSE_AT_ITEM  = 700;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int IN_PAD_W       = IN_TDATA_W - NEW_VALUE_LSB - FIELD_W;

    typedef logic [DATA_WIDTH-1:0] word_t;

    // One row of the directed stimulus table.
    typedef struct {
        oqd_cmd_t    cmd;
        word_t       value;
        word_t       new_value;
        bit          typed;
        oqd_status_t status;
        int unsigned count;
    } cmd_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Predictor state: the words held, head first.
    word_t       held_words[$];
    oqd_result_t pending_results[$];
    cmd_row_t    directed_rows[$];

    int          failures      = 0;
    int unsigned items_sent    = 0;
    int unsigned results_taken = 0;
    int unsigned idle_cycles   = 0;

    ordered_queue_delete_by_value #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Applies one command to the predicted queue and returns its result.
    function automatic oqd_result_t apply_command(input oqd_cmd_t cmd, input word_t key,
                                                  input word_t repl);
        oqd_result_t res;
        int          hit;
        hit = -1;
        for (int i = 0; i < held_words.size(); i++)
        begin
            if (hit < 0 && held_words[i] == key)
                hit = i;
        end
        res.status = ST_DONE;
        case (cmd)
            CMD_APPEND:
            begin
                if (held_words.size() >= QUEUE_DEPTH)
                    res.status = ST_FULL;
                else
                    held_words.push_back(key);
            end
            CMD_REMOVE:
            begin
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                    held_words.delete(hit);
            end
            CMD_REPLACE:
            begin
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                    held_words[hit] = repl;
            end
            default:
                held_words.delete();
        endcase
        res.entry_count = COUNT_OUT_W'(held_words.size());
        return res;
    endfunction

    // Random word: mostly full range, with a small pool and the extremes for duplicates.
    function automatic word_t random_word();
        word_t w;
        case ($urandom_range(0, 5))
            0: w = word_t'($urandom_range(0, 3));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: w = 32'h8000_0000;
                    1: w = 32'h7FFF_FFFF;
                    2: w = 32'hFFFF_FFFF;
                    default: w = 32'h0000_0000;
                endcase
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Search key: usually a word currently held, otherwise a random one.
    function automatic word_t choose_key();
        word_t w;
        if (held_words.size() != 0 && $urandom_range(0, 3) != 0)
            w = held_words[$urandom_range(0, held_words.size() - 1)];
        else
            w = random_word();
        return w;
    endfunction

    // Command choice that steers the fill level toward a target.
    function automatic oqd_cmd_t choose_cmd(input int unsigned fill_target);
        int unsigned r;
        oqd_cmd_t    c;
        r = $urandom_range(0, 99);
        if (r < 2)
            c = CMD_CLEAR;
        else if (held_words.size() < fill_target)
            c = (r < 67) ? CMD_APPEND : (r < 79) ? CMD_REMOVE : CMD_REPLACE;
        else if (held_words.size() > fill_target)
            c = (r < 17) ? CMD_APPEND : (r < 77) ? CMD_REMOVE : CMD_REPLACE;
        else
            c = (r < 32) ? CMD_APPEND : (r < 67) ? CMD_REMOVE : CMD_REPLACE;
        return c;
    endfunction

    // Offers one command and waits for its transfer; returns the predicted result.
    task automatic send_cmd(input oqd_cmd_t cmd, input word_t value, input word_t new_value,
                            output oqd_result_t predicted);
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_PAD_W{1'b0}}, new_value, value, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_command(cmd, value, new_value);
        items_sent++;
    endtask

    // Random gap on the input side, left out in some stretches and at the end.
    task automatic input_gap();
        if (items_sent + CALM_ITEMS < TOTAL_ITEMS && (items_sent / 120) % 3 != 2
            && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic add_row(input oqd_cmd_t cmd, input word_t value, input word_t new_value,
                           input bit typed, input oqd_status_t status, input int unsigned count);
        cmd_row_t row;
        row.cmd       = cmd;
        row.value     = value;
        row.new_value = new_value;
        row.typed     = typed;
        row.status    = status;
        row.count     = count;
        directed_rows.push_back(row);
    endtask

    // Reset and stimulus.
    initial
    begin
        oqd_result_t predicted;
        oqd_result_t typed_res;
        int unsigned fill_target;
        int unsigned phase_left;
        oqd_cmd_t    cmd;
        word_t       value;
        word_t       new_value;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty queue, extremes, duplicates, head and tail removal.
        add_row(CMD_REMOVE,  32'h0000_0000, 32'h0000_0000, 1, ST_NOT_FOUND, 0);
        add_row(CMD_REPLACE, 32'h0000_0000, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 0);
        add_row(CMD_CLEAR,   32'h0000_0000, 32'h0000_0000, 1, ST_DONE,      0);
        add_row(CMD_APPEND,  32'h8000_0000, 32'h0000_0000, 1, ST_DONE,      1);
        add_row(CMD_APPEND,  32'h7FFF_FFFF, 32'h0000_0000, 1, ST_DONE,      2);
        add_row(CMD_APPEND,  32'hFFFF_FFFF, 32'h0000_0000, 1, ST_DONE,      3);
        add_row(CMD_APPEND,  32'h0000_0000, 32'h0000_0000, 1, ST_DONE,      4);
        add_row(CMD_APPEND,  32'h7FFF_FFFF, 32'h8000_0000, 0, ST_DONE,      0);
        add_row(CMD_REMOVE,  32'h1234_5678, 32'h0000_0000, 1, ST_NOT_FOUND, 5);
        add_row(CMD_REPLACE, 32'h5555_5555, 32'h0000_0000, 1, ST_NOT_FOUND, 5);
        add_row(CMD_REMOVE,  32'h7FFF_FFFF, 32'h0000_0000, 0, ST_DONE,      0);
        add_row(CMD_REPLACE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 0, ST_DONE,      0);
        add_row(CMD_REMOVE,  32'hFFFF_FFFF, 32'h0000_0000, 0, ST_DONE,      0);
        add_row(CMD_REMOVE,  32'h8000_0000, 32'h0000_0000, 0, ST_DONE,      0);
        add_row(CMD_REMOVE,  32'h7FFF_FFFF, 32'h0000_0000, 0, ST_DONE,      0);
        add_row(CMD_REPLACE, 32'hAAAA_AAAA, 32'h5555_5555, 0, ST_DONE,      0);
        add_row(CMD_REMOVE,  32'h7FFF_FFFF, 32'h8000_0000, 0, ST_DONE,      0);
        add_row(CMD_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_DONE,      0);
        add_row(CMD_REMOVE,  32'h0000_0000, 32'h0000_0000, 1, ST_NOT_FOUND, 0);
        add_row(CMD_APPEND,  32'h0000_0000, 32'h0000_0000, 1, ST_DONE,      1);
        add_row(CMD_REMOVE,  32'h0000_0000, 32'h0000_0000, 1, ST_DONE,      0);

        foreach (directed_rows[i])
        begin
            send_cmd(directed_rows[i].cmd, directed_rows[i].value,
                     directed_rows[i].new_value, predicted);
            if (directed_rows[i].typed)
            begin
                typed_res.status      = directed_rows[i].status;
                typed_res.entry_count = COUNT_OUT_W'(directed_rows[i].count);
                pending_results.push_back(typed_res);
            end
            else
            begin
                pending_results.push_back(predicted);
            end
            input_gap();
        end

        // Random part: the fill level wanders between targets, the first one being full.
        fill_target = QUEUE_DEPTH;
        phase_left  = 250;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: fill_target = $urandom_range(0, 4);
                    1: fill_target = $urandom_range(5, 40);
                    2: fill_target = QUEUE_DEPTH;
                    default: fill_target = $urandom_range(QUEUE_DEPTH - 6, QUEUE_DEPTH);
                endcase
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;

            // Once in the run, hold the input until every result is back.
            if (items_sent == PAUSE_AT_ITEM)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end

            cmd       = choose_cmd(fill_target);
            value     = (cmd == CMD_APPEND) ? random_word() : choose_key();
            new_value = random_word();
            send_cmd(cmd, value, new_value, predicted);
            pending_results.push_back(predicted);
            input_gap();
        end
        s_tvalid <= 1'b0;

        // Wait for the last results, then keep watching for anything unexpected.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side ready: random stall bursts and one long hold-off.
    initial
    begin
        bit held_once;
        held_once = 0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_once && results_taken >= HOLD_AT_RESULT)
            begin
                held_once = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (results_taken + CALM_ITEMS < TOTAL_ITEMS && (results_taken / 100) % 3 != 1
                     && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        oqd_result_t want;
        if (m_tvalid && m_tready)
        begin
            results_taken <= results_taken + 1;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d, entry_count %0d",
                       m_tdata[1:0], m_tdata[8:2]);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] != want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, m_tdata[1:0]);
                    failures++;
                end
                if (m_tdata[8:2] != want.entry_count)
                begin
                    $error("entry_count mismatch: expected %0d, actual %0d",
                           want.entry_count, m_tdata[8:2]);
                    failures++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> filelist.f
rtl/oqd_pkg.sv
rtl/oqd_front.sv
rtl/oqd_fifo.sv
rtl/oqd_back.sv
rtl/ordered_queue_delete_by_value.sv
rtl/oqd_checker.sv
tb/sv/ordered_queue_delete_by_value_tb.sv
